/* rtl/core/coq_pkg.sv */
// shared types, codes and field positions for the commit order ticket queue
package coq_pkg;

    localparam int WORKER_W        = 4;
    localparam int TICKET_W        = 64;
    localparam int NUM_WORKERS_DEF = 16;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 136;

    // output tdata field positions, lowest bit of each field
    localparam int OUT_FOUND      = 0;
    localparam int OUT_WORKER_LO  = 1;
    localparam int OUT_TICKET_LO  = 5;
    localparam int OUT_RELEASE_LO = 69;
    localparam int OUT_EMPTY      = 133;
    localparam int OUT_STATUS_LO  = 134;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_DUP    = 2'd2
    } status_t;

    // contents of one queue slot
    typedef struct packed {
        logic                valid;
        logic [WORKER_W-1:0] worker;
        logic [TICKET_W-1:0] ticket;
        logic [TICKET_W-1:0] follow;
    } entry_t;

    // broadcast to every slot of the row
    typedef struct packed {
        logic                push;
        logic                pop;
        logic                remove;
        logic [WORKER_W-1:0] worker;
        logic [TICKET_W-1:0] ticket;
        logic [TICKET_W-1:0] follow;
    } cell_ctrl_t;

endpackage

/* rtl/core/coq_cell.sv */
// one slot of the commit order row: holds a worker with its tickets
module coq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  coq_pkg::cell_ctrl_t ctrl,
    input  logic               left_valid,
    input  logic               drop_in,
    input  coq_pkg::entry_t    right,
    input  logic               right_match,
    output coq_pkg::entry_t    entry,
    output logic               match,
    output logic               drop_out
);
    import coq_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [WORKER_W-1:0] worker_reg;
    logic [WORKER_W-1:0] worker_next;
    logic [TICKET_W-1:0] ticket_reg;
    logic [TICKET_W-1:0] ticket_next;
    logic [TICKET_W-1:0] follow_reg;
    logic [TICKET_W-1:0] follow_next;

    assign match    = valid_reg && (worker_reg == ctrl.worker);
    // set from the matching slot rightward: these slots close the gap
    assign drop_out = drop_in | match;

    always_comb
    begin
        valid_next  = valid_reg;
        worker_next = worker_reg;
        ticket_next = ticket_reg;
        follow_next = follow_reg;
        if (ctrl.pop || (ctrl.remove && drop_out))
        begin
            valid_next  = right.valid;
            worker_next = right.worker;
            ticket_next = right.ticket;
            follow_next = right.follow;
        end
        else if (ctrl.remove && right_match)
        begin
            // predecessor inherits the removed worker's follow-on ticket
            follow_next = right.follow;
        end
        else if (ctrl.push && left_valid && !valid_reg)
        begin
            valid_next  = 1'b1;
            worker_next = ctrl.worker;
            ticket_next = ctrl.ticket;
            follow_next = ctrl.follow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        worker_reg <= worker_next;
        ticket_reg <= ticket_next;
        follow_reg <= follow_next;
    end

    assign entry = '{valid: valid_reg, worker: worker_reg, ticket: ticket_reg,
                     follow: follow_reg};

endmodule

/* rtl/core/commit_order_ticket_queue.sv */
// top level of the commit order ticket queue: request control and the slot row
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+------------------------------------
//   s_        | in        | s_tvalid / s_tready  | op, worker
//   m_        | out       | m_tvalid / m_tready  | found, worker_out, ticket,
//             |           |                      | release_ticket, queue_empty, status
//
// each request is latched while s_tready is high, in the idle state; in the execute state
// the worker number is matched against all slots and the row and the output register are
// updated, and the result is registered.
// a stalled output register holds the execute state until it empties.
// reset empties every slot and sets the next ticket to 2; no clearing pass.
module commit_order_ticket_queue
#(
    parameter int NUM_WORKERS = coq_pkg::NUM_WORKERS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [coq_pkg::S_DATA_W-1:0]  s_tdata,  // op[1:0], worker[5:2], zero[7:6]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [coq_pkg::M_DATA_W-1:0]  m_tdata   // found[0], worker_out[4:1],
                                                    // ticket[68:5], release_ticket[132:69],
                                                    // queue_empty[133], status[135:134]
);
    import coq_pkg::*;

    localparam int CNT_W = $clog2(NUM_WORKERS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    op_t                 op_reg;
    logic [WORKER_W-1:0] worker_reg;
    logic [TICKET_W-1:0] next_ticket_reg;
    logic [TICKET_W-1:0] next_ticket_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                s_accept;
    logic                commit;
    logic [TICKET_W-1:0] ticket_inc;
    logic [TICKET_W-1:0] follow_new;
    logic                in_range;
    logic                any_match;
    logic                full;
    logic                empty;
    logic                push_ok;
    logic                pop_ok;
    logic                rem_ok;
    logic                found_c;
    logic [WORKER_W-1:0] wout_c;
    logic [TICKET_W-1:0] tick_c;
    logic [TICKET_W-1:0] rel_c;
    status_t             status_c;
    logic [CNT_W-1:0]    count_after;
    logic [M_DATA_W-1:0] m_tdata_next;

    cell_ctrl_t            cell_ctrl;
    entry_t                entries [NUM_WORKERS+1];
    logic [NUM_WORKERS:0]  match_vec;
    logic [NUM_WORKERS:0]  drop;
    logic [NUM_WORKERS-1:0] left_valid;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    // follow-on ticket, which is also the next ticket handed out
    assign ticket_inc = next_ticket_reg + TICKET_W'(1);
    assign follow_new = (ticket_inc <= TICKET_W'(1)) ? TICKET_W'(2) : ticket_inc;

    assign in_range  = ({5'd0, worker_reg} < 9'(NUM_WORKERS));
    assign any_match = |match_vec[NUM_WORKERS-1:0];
    assign full      = (count_reg == CNT_W'(NUM_WORKERS));
    assign empty     = (count_reg == '0);

    // slot row
    assign entries[NUM_WORKERS]   = '0;
    assign match_vec[NUM_WORKERS] = 1'b0;
    assign drop[0]                = 1'b0;

    assign cell_ctrl.push   = commit && push_ok;
    assign cell_ctrl.pop    = commit && pop_ok;
    assign cell_ctrl.remove = commit && rem_ok;
    assign cell_ctrl.worker = worker_reg;
    assign cell_ctrl.ticket = next_ticket_reg;
    assign cell_ctrl.follow = follow_new;

    for (genvar i = 0; i < NUM_WORKERS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_valid[i] = 1'b1;
        end
        else
        begin : g_body
            assign left_valid[i] = entries[i-1].valid;
        end

        coq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .left_valid  (left_valid[i]),
            .drop_in     (drop[i]),
            .right       (entries[i+1]),
            .right_match (match_vec[i+1]),
            .entry       (entries[i]),
            .match       (match_vec[i]),
            .drop_out    (drop[i+1])
        );
    end

    // result of the latched request
    always_comb
    begin
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        rem_ok   = 1'b0;
        found_c  = 1'b0;
        wout_c   = '0;
        tick_c   = '0;
        rel_c    = '0;
        status_c = STATUS_OK;
        case (op_reg)
            OP_PUSH:
            begin
                if (!in_range)
                begin
                    status_c = STATUS_ABSENT;
                end
                else if (any_match || full)
                begin
                    status_c = STATUS_DUP;
                end
                else
                begin
                    push_ok = 1'b1;
                    found_c = 1'b1;
                    wout_c  = worker_reg;
                    tick_c  = next_ticket_reg;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status_c = STATUS_ABSENT;
                end
                else
                begin
                    pop_ok  = 1'b1;
                    found_c = 1'b1;
                    wout_c  = entries[0].worker;
                    rel_c   = entries[0].follow;
                end
            end
            OP_REMOVE:
            begin
                if (!any_match)
                begin
                    status_c = STATUS_ABSENT;
                end
                else
                begin
                    rem_ok  = 1'b1;
                    found_c = 1'b1;
                    wout_c  = worker_reg;
                    // removing the head releases like a pop
                    rel_c   = match_vec[0] ? entries[0].follow : '0;
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_c = STATUS_ABSENT;
                end
                else
                begin
                    found_c = 1'b1;
                    wout_c  = entries[0].worker;
                    tick_c  = entries[0].ticket;
                end
            end
            default:
            begin
                status_c = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        count_after = count_reg;
        if (push_ok)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (pop_ok || rem_ok)
        begin
            count_after = count_reg - CNT_W'(1);
        end
    end

    assign m_tdata_next = {status_c, (count_after == '0), rel_c, tick_c, wout_c, found_c};

    always_comb
    begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg;
        count_next       = count_reg;
        next_ticket_next = next_ticket_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    count_next    = count_after;
                    if (push_ok)
                    begin
                        next_ticket_next = follow_new;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            count_reg       <= '0;
            next_ticket_reg <= TICKET_W'(2);
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            count_reg       <= count_next;
            next_ticket_reg <= next_ticket_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg     <= op_t'(s_tdata[1:0]);
            worker_reg <= s_tdata[2 +: WORKER_W];
        end
        if (commit)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/coq_checker.sv */
// port checker for the commit order ticket queue and its bind
module coq_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [coq_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [coq_pkg::M_DATA_W-1:0] m_tdata
);
    import coq_pkg::*;

    logic                found;
    logic [WORKER_W-1:0] worker_out;
    logic [TICKET_W-1:0] ticket;
    logic [TICKET_W-1:0] release_ticket;
    logic [1:0]          status;

    assign found          = m_tdata[OUT_FOUND];
    assign worker_out     = m_tdata[OUT_WORKER_LO +: WORKER_W];
    assign ticket         = m_tdata[OUT_TICKET_LO +: TICKET_W];
    assign release_ticket = m_tdata[OUT_RELEASE_LO +: TICKET_W];
    assign status         = m_tdata[OUT_STATUS_LO +: 2];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: the input closes right after a request
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (found == (status == STATUS_OK)))
        else $error("found and status disagree");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !found |-> (worker_out == '0) && (ticket == '0) && (release_ticket == '0))
        else $error("fields not cleared on a miss");

    // reserved values are never handed out, and no request both assigns and releases
    a_ticket_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ticket != TICKET_W'(1)) && (release_ticket != TICKET_W'(1))
                     && ((ticket == '0) || (release_ticket == '0)))
        else $error("bad ticket value");

endmodule

bind commit_order_ticket_queue coq_checker u_coq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/tb_commit_order_ticket_queue.sv */
// testbench for the commit order ticket queue: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_commit_order_ticket_queue;
    import coq_pkg::*;

    localparam int WORKER_COUNT = NUM_WORKERS_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1900;

    typedef struct {
        logic                found;
        logic [WORKER_W-1:0] worker_out;
        logic [TICKET_W-1:0] ticket;
        logic [TICKET_W-1:0] release_ticket;
        logic                queue_empty;
        status_t             status;
    } commit_result_t;

    class commit_order_scoreboard;
        logic [WORKER_W-1:0] commit_order[$];
        logic [TICKET_W-1:0] ticket_of[WORKER_COUNT];
        logic [TICKET_W-1:0] follow_of[WORKER_COUNT];
        logic [TICKET_W-1:0] next_ticket;
        commit_result_t      pending_results[$];
        int                  mismatch_count;

        function new();
            for (int i = 0; i < WORKER_COUNT; i++)
            begin
                ticket_of[i] = '0;
                follow_of[i] = '0;
            end
            next_ticket    = '0;
            mismatch_count = 0;
        endfunction

        // tickets 0 and 1 are reserved
        function logic [TICKET_W-1:0] past_reserved(logic [TICKET_W-1:0] v);
            return (v <= 1) ? TICKET_W'(2) : v;
        endfunction

        function void note_request(op_t op, logic [WORKER_W-1:0] w);
            commit_result_t      r;
            int                  pos;
            logic [WORKER_W-1:0] head;
            logic [TICKET_W-1:0] t;
            logic [TICKET_W-1:0] f;
            r.found          = 1'b0;
            r.worker_out     = '0;
            r.ticket         = '0;
            r.release_ticket = '0;
            r.status         = STATUS_OK;
            case (op)
                OP_PUSH:
                begin
                    if (ticket_of[w] != 0 || commit_order.size() >= WORKER_COUNT)
                        r.status = STATUS_DUP;
                    else
                    begin
                        t            = past_reserved(next_ticket);
                        next_ticket  = t + TICKET_W'(1);
                        ticket_of[w] = t;
                        follow_of[w] = past_reserved(t + TICKET_W'(1));
                        commit_order.push_back(w);
                        r.found      = 1'b1;
                        r.worker_out = w;
                        r.ticket     = t;
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (commit_order.size() == 0)
                        r.status = STATUS_ABSENT;
                    else
                    begin
                        head         = commit_order[0];
                        r.found      = 1'b1;
                        r.worker_out = head;
                        if (op == OP_PEEK)
                            r.ticket = ticket_of[head];
                        else
                        begin
                            r.release_ticket = follow_of[head];
                            ticket_of[head]  = '0;
                            follow_of[head]  = '0;
                            void'(commit_order.pop_front());
                        end
                    end
                end
                default:
                begin
                    pos = -1;
                    for (int i = 0; i < commit_order.size(); i++)
                        if (commit_order[i] == w && pos < 0)
                            pos = i;
                    if (pos < 0)
                        r.status = STATUS_ABSENT;
                    else
                    begin
                        f            = follow_of[w];
                        ticket_of[w] = '0;
                        follow_of[w] = '0;
                        // the predecessor takes over the follow-on ticket
                        if (pos == 0)
                            r.release_ticket = f;
                        else
                            follow_of[commit_order[pos-1]] = f;
                        commit_order.delete(pos);
                        r.found      = 1'b1;
                        r.worker_out = w;
                    end
                end
            endcase
            r.queue_empty = (commit_order.size() == 0);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [TICKET_W-1:0] got, logic [TICKET_W-1:0] want);
            $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
            mismatch_count++;
        endtask

        task check_result(logic [M_DATA_W-1:0] d);
            commit_result_t e;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", d[TICKET_W-1:0], '0);
            else
            begin
                e = pending_results.pop_front();
                if (d[OUT_FOUND] !== e.found)
                    report_mismatch("found", d[OUT_FOUND], e.found);
                if (d[OUT_WORKER_LO +: WORKER_W] !== e.worker_out)
                    report_mismatch("worker_out", d[OUT_WORKER_LO +: WORKER_W], e.worker_out);
                if (d[OUT_TICKET_LO +: TICKET_W] !== e.ticket)
                    report_mismatch("ticket", d[OUT_TICKET_LO +: TICKET_W], e.ticket);
                if (d[OUT_RELEASE_LO +: TICKET_W] !== e.release_ticket)
                    report_mismatch("release_ticket", d[OUT_RELEASE_LO +: TICKET_W],
                                    e.release_ticket);
                if (d[OUT_EMPTY] !== e.queue_empty)
                    report_mismatch("queue_empty", d[OUT_EMPTY], e.queue_empty);
                if (d[OUT_STATUS_LO +: 2] !== e.status)
                    report_mismatch("status", d[OUT_STATUS_LO +: 2], e.status);
            end
        endtask
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    commit_order_scoreboard sb;
    int idle_cycles = 0;
    int ready_cycle = 0;
    int ready_mode  = 0;

    commit_order_ticket_queue dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: switches at random among stall patterns, one of them always ready
    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 64 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (ready_cycle % 4 == 0);
            default: m_tready <= (ready_cycle % 8 < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(op_t op, logic [WORKER_W-1:0] w);
        s_tdata  <= {2'b00, w, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, w);
    endtask

    // hold off new requests until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(bit grow);
        int                  roll;
        op_t                 op;
        logic [WORKER_W-1:0] w;
        roll = $urandom_range(0, 99);
        w    = WORKER_W'($urandom_range(0, WORKER_COUNT - 1));
        if (grow)
            op = (roll < 70) ? OP_PUSH : (roll < 80) ? OP_POP : (roll < 90) ? OP_REMOVE : OP_PEEK;
        else
            op = (roll < 15) ? OP_PUSH : (roll < 50) ? OP_POP : (roll < 85) ? OP_REMOVE : OP_PEEK;
        // removes mostly hit a queued worker, anywhere in the order
        if (op == OP_REMOVE && sb.commit_order.size() != 0 && $urandom_range(0, 3) != 0)
            w = sb.commit_order[$urandom_range(0, sb.commit_order.size() - 1)];
        send_request(op, w);
    endtask

    initial
    begin
        int  burst_left;
        int  gap;
        int  mode_left;
        bit  grow;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_PEEK, 4'd0);
        send_request(OP_POP, 4'd0);
        send_request(OP_REMOVE, 4'd5);
        send_request(OP_PUSH, 4'd15);
        send_request(OP_PUSH, 4'd0);
        send_request(OP_PUSH, 4'd10);
        send_request(OP_PUSH, 4'd15);
        send_request(OP_PEEK, 4'd3);
        send_request(OP_REMOVE, 4'd0);
        send_request(OP_REMOVE, 4'd10);
        send_request(OP_REMOVE, 4'd15);
        send_request(OP_PUSH, 4'd5);
        send_request(OP_POP, 4'd9);
        send_request(OP_POP, 4'd0);
        send_request(OP_REMOVE, 4'd15);
        drain_results();

        burst_left = 0;
        mode_left  = 0;
        grow       = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (mode_left == 0)
            begin
                grow      = !grow;
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (i % 500 == 499)
                drain_results();
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            send_random(grow);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/coq_pkg.sv
rtl/core/coq_cell.sv
rtl/core/commit_order_ticket_queue.sv
rtl/core/coq_checker.sv
tb/sv/tb_commit_order_ticket_queue.sv
